// ===== src/sdc_pkg.sv =====
package sdc_pkg;

  // Keyboard grid geometry.
  localparam int unsigned GRID_COLS = 14;
  localparam int unsigned GRID_ROWS = 4;

  // Field widths of the items.
  localparam int unsigned STEP_W  = 11;
  localparam int unsigned COL_W   = 5;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned PITCH_W = 26;
  localparam int unsigned TAB_W   = 19;

  // Largest column and row after clamping.
  localparam logic [COL_W-2:0] COL_MAX = (COL_W-1)'(GRID_COLS - 1);
  localparam logic [ROW_W-2:0] ROW_MAX = (ROW_W-1)'(GRID_ROWS - 1);

  // One octave, 1200 cents, with 8 fraction bits.
  localparam logic [PITCH_W-1:0] OCTAVE_Q8 = 26'd307200;

  // Tuning ids held in the configuration register.
  typedef enum logic [7:0] {
    SCALE_EDO12 = 8'd0,
    SCALE_EDO19 = 8'd1,
    SCALE_EDO31 = 8'd2,
    SCALE_JI11  = 8'd3,
    SCALE_PENTA = 8'd4,
    SCALE_MAJOR = 8'd5,
    SCALE_WOLF  = 8'd6
  } scale_e;

  // Input item as held in the input register.
  typedef struct packed {
    logic                     operation;
    logic signed [STEP_W-1:0] step_index;
    logic signed [COL_W-1:0]  grid_column;
    logic signed [ROW_W-1:0]  grid_row;
  } in_item_t;

  // Reciprocals for degree / n, exact for degrees below 1024 (shift 16).
  localparam logic [13:0] RECIP_14 = 14'd4682;
  localparam logic [13:0] RECIP_5  = 14'd13108;
  localparam logic [13:0] RECIP_7  = 14'd9363;

  // Equal temperaments: m * 307200 / n = m * INT + (m * FRAC) / n.
  // The remaining division uses a reciprocal with shift 20, exact over
  // the reachable range.
  localparam logic [13:0] EDO19_INT   = 14'd16168;
  localparam logic [4:0]  EDO19_FRAC  = 5'd8;
  localparam logic [4:0]  EDO19_HALF  = 5'd9;
  localparam logic [15:0] EDO19_RECIP = 16'd55189;
  localparam logic [13:0] EDO31_INT   = 14'd9909;
  localparam logic [4:0]  EDO31_FRAC  = 5'd21;
  localparam logic [4:0]  EDO31_HALF  = 5'd15;
  localparam logic [15:0] EDO31_RECIP = 16'd33826;

  // 11-limit just intonation, one entry per column.
  function automatic logic [TAB_W-1:0] ji11_entry(input logic [3:0] idx);
    logic [TAB_W-1:0] val;
    case (idx)
      4'd0:    val = 19'd0;
      4'd1:    val = 19'd38563;
      4'd2:    val = 19'd52201;
      4'd3:    val = 19'd68319;
      4'd4:    val = 19'd80804;
      4'd5:    val = 19'd98896;
      4'd6:    val = 19'd127500;
      4'd7:    val = 19'd141137;
      4'd8:    val = 19'd179700;
      4'd9:    val = 19'd195818;
      4'd10:   val = 19'd208304;
      4'd11:   val = 19'd226396;
      4'd12:   val = 19'd248019;
      4'd13:   val = 19'd268637;
      default: val = 19'd0;
    endcase
    return val;
  endfunction

  // Just pentatonic scale.
  function automatic logic [TAB_W-1:0] penta_entry(input logic [3:0] idx);
    logic [TAB_W-1:0] val;
    case (idx)
      4'd0:    val = 19'd0;
      4'd1:    val = 19'd52198;
      4'd2:    val = 19'd98893;
      4'd3:    val = 19'd179712;
      4'd4:    val = 19'd226406;
      default: val = 19'd0;
    endcase
    return val;
  endfunction

  // Just major scale.
  function automatic logic [TAB_W-1:0] major_entry(input logic [3:0] idx);
    logic [TAB_W-1:0] val;
    case (idx)
      4'd0:    val = 19'd0;
      4'd1:    val = 19'd52198;
      4'd2:    val = 19'd98893;
      4'd3:    val = 19'd127488;
      4'd4:    val = 19'd179712;
      4'd5:    val = 19'd226406;
      4'd6:    val = 19'd278605;
      default: val = 19'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/sdc_in_if.sv =====
interface sdc_in_if;
  import sdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [STEP_W-1:0] step_index;
  logic signed [COL_W-1:0]  grid_column;
  logic signed [ROW_W-1:0]  grid_row;

  modport source (output valid, operation, step_index, grid_column, grid_row, input ready);
  modport sink (input valid, operation, step_index, grid_column, grid_row, output ready);
endinterface

// ===== src/sdc_out_if.sv =====
interface sdc_out_if;
  import sdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PITCH_W-1:0] pitch_cents_q8;

  modport source (output valid, pitch_cents_q8, input ready);
  modport sink (input valid, pitch_cents_q8, output ready);
endinterface

// ===== src/scale_degree_to_cents.sv =====
// Scale degree to pitch converter.
// The req_i channel takes one item per lookup: operation selects a linear
// step (step_index) or a key on the grid (grid_column, grid_row). The rsp_o
// channel returns exactly one item per lookup, pitch_cents_q8, in 1/256
// cent units. The tuning comes from the scale_select register, written on
// scale_select_we_i; the user must write it only while no lookup is in
// flight, which the block itself does not enforce. An accepted item waits
// in the input register, with all arithmetic between it and the result
// register, and is shown on rsp_o once the result register loads it.
// Throughput is one item per cycle while the receiver takes results; it is
// set by the single result register, reloaded in the cycle it is taken.
// Reset clears both valid flags and selects 12-EDO; no clearing pass.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item, after which req_i.ready
// drops until the result is taken.
module scale_degree_to_cents (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scale_select_we_i,
  input  logic [7:0]          scale_select_i,
  sdc_in_if.sink              req_i,
  sdc_out_if.source           rsp_o
);
  import sdc_pkg::*;

  logic [7:0]         scale_q;
  logic               s1_valid_q, s1_valid_d;
  in_item_t           s1_q;
  logic               s2_valid_q, s2_valid_d;
  logic [PITCH_W-1:0] pitch_q;
  logic [PITCH_W-1:0] pitch_d;
  logic               req_acc;
  logic               s2_load;

  logic [9:0]             step_u;
  logic [COL_W-2:0]       col_u;
  logic [ROW_W-2:0]       row_u;
  logic [3:0]             row_mul;
  logic [6:0]             grid_deg;
  logic [9:0]             deg;
  logic [3:0]             tab_div;
  logic [13:0]            tab_recip;
  logic [23:0]            tab_prod;
  logic [7:0]             tab_q;
  logic [9:0]             tab_rem_w;
  logic [3:0]             tab_rem;
  logic [8:0]             tab_oct;
  logic [TAB_W-1:0]       tab_entry;
  logic [PITCH_W-1:0]     tab_val;
  logic [4:0]             edo_base;
  logic [13:0]            edo_int;
  logic [4:0]             edo_frac;
  logic [4:0]             edo_half;
  logic [15:0]            edo_recip;
  logic [10:0]            edo_m;
  logic [14:0]            edo_x;
  logic [30:0]            edo_prod;
  logic [PITCH_W-1:0]     edo_val;
  logic [PITCH_W-1:0]     edo12_val;
  logic [9:0]             wolf_k;
  logic [PITCH_W-1:0]     wolf_val;
  logic [PITCH_W-1:0]     fallback_val;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_EDO12;
    end else if (scale_select_we_i) begin
      scale_q <= scale_select_i;
    end
  end

  // Handshake: the result register reloads when empty or being taken.
  assign s2_load     = !s2_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s2_load;
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_q.operation   <= req_i.operation;
      s1_q.step_index  <= req_i.step_index;
      s1_q.grid_column <= req_i.grid_column;
      s1_q.grid_row    <= req_i.grid_row;
    end
  end

  // Clamp the position to the valid step range and to the grid.
  always_comb begin
    step_u = s1_q.step_index[STEP_W-1] ? '0 : s1_q.step_index[STEP_W-2:0];
    if (s1_q.grid_column[COL_W-1]) begin
      col_u = '0;
    end else if (s1_q.grid_column[COL_W-2:0] > COL_MAX) begin
      col_u = COL_MAX;
    end else begin
      col_u = s1_q.grid_column[COL_W-2:0];
    end
    if (s1_q.grid_row[ROW_W-1]) begin
      row_u = '0;
    end else if (s1_q.grid_row[ROW_W-2:0] > ROW_MAX) begin
      row_u = ROW_MAX;
    end else begin
      row_u = s1_q.grid_row[ROW_W-2:0];
    end
  end

  // Steps per grid row for each tuning; zero where the row is handled apart or ignored.
  always_comb begin
    case (scale_q)
      SCALE_EDO12: row_mul = 4'd5;
      SCALE_EDO19: row_mul = 4'd8;
      SCALE_EDO31: row_mul = 4'd13;
      SCALE_PENTA: row_mul = 4'd2;
      SCALE_MAJOR: row_mul = 4'd2;
      default:     row_mul = 4'd0;
    endcase
  end

  assign grid_deg = 7'(col_u) + 7'(row_mul) * 7'(row_u);
  assign deg      = s1_q.operation ? 10'(grid_deg) : step_u;

  // Table tunings: split the degree into octave and scale index.
  always_comb begin
    case (scale_q)
      SCALE_PENTA: begin
        tab_div   = 4'd5;
        tab_recip = RECIP_5;
      end
      SCALE_MAJOR: begin
        tab_div   = 4'd7;
        tab_recip = RECIP_7;
      end
      default: begin
        tab_div   = 4'(GRID_COLS);
        tab_recip = RECIP_14;
      end
    endcase
  end

  assign tab_prod  = 24'(deg) * 24'(tab_recip);
  assign tab_q     = tab_prod[23:16];
  assign tab_rem_w = deg - 10'(tab_q) * 10'(tab_div);
  assign tab_rem   = tab_rem_w[3:0];

  // In the just grid each row is one octave higher.
  assign tab_oct = 9'(tab_q)
                 + ((s1_q.operation && scale_q == SCALE_JI11) ? 9'(row_u) : 9'd0);

  always_comb begin
    case (scale_q)
      SCALE_PENTA: tab_entry = penta_entry(tab_rem);
      SCALE_MAJOR: tab_entry = major_entry(tab_rem);
      default:     tab_entry = ji11_entry(tab_rem);
    endcase
  end

  assign tab_val = 26'(tab_entry) + 26'(tab_oct) * OCTAVE_Q8;

  // 19- and 31-EDO, rounded half up, with the octave lift folded into m.
  always_comb begin
    if (scale_q == SCALE_EDO31) begin
      edo_base  = 5'd31;
      edo_int   = EDO31_INT;
      edo_frac  = EDO31_FRAC;
      edo_half  = EDO31_HALF;
      edo_recip = EDO31_RECIP;
    end else begin
      edo_base  = 5'd19;
      edo_int   = EDO19_INT;
      edo_frac  = EDO19_FRAC;
      edo_half  = EDO19_HALF;
      edo_recip = EDO19_RECIP;
    end
  end

  assign edo_m    = 11'(deg) + 11'(edo_base);
  assign edo_x    = 15'(16'(edo_m) * 16'(edo_frac)) + 15'(edo_half);
  assign edo_prod = 31'(edo_x) * 31'(edo_recip);
  assign edo_val  = 26'(edo_m) * 26'(edo_int) + 26'(edo_prod[30:20]);

  // Linear tunings.
  assign edo12_val    = OCTAVE_Q8 + 26'(deg) * 26'd25600;
  assign fallback_val = 26'(deg) * 26'd25600;
  assign wolf_k       = s1_q.operation ? 10'(col_u) : step_u;
  assign wolf_val     = OCTAVE_Q8 + 26'(wolf_k) * 26'd15872
                      + (s1_q.operation ? 26'(row_u) * 26'd163072 : 26'd0);

  // Pick the result of the selected tuning.
  always_comb begin
    case (scale_q)
      SCALE_EDO12: pitch_d = edo12_val;
      SCALE_EDO19: pitch_d = edo_val;
      SCALE_EDO31: pitch_d = edo_val;
      SCALE_JI11:  pitch_d = tab_val;
      SCALE_PENTA: pitch_d = tab_val;
      SCALE_MAJOR: pitch_d = tab_val;
      SCALE_WOLF:  pitch_d = wolf_val;
      default:     pitch_d = fallback_val;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      pitch_q <= pitch_d;
    end
  end

  assign rsp_o.valid          = s2_valid_q;
  assign rsp_o.pitch_cents_q8 = pitch_q;

`ifndef SYNTHESIS
  // An item leaving the input register lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_load |=> s2_valid_q)
    else $error("item lost between input and result register");

  // A new item is only taken when the input register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> (!s1_valid_q || s2_load))
    else $error("input register overwritten");

  // The scale index of a table tuning stays below the scale length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> tab_rem < tab_div)
    else $error("table index out of range");

  // Tunings with the octave lift never go below one octave.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (scale_q == SCALE_EDO12 || scale_q == SCALE_EDO19 ||
                   scale_q == SCALE_EDO31 || scale_q == SCALE_WOLF)
    |-> pitch_d >= OCTAVE_Q8)
    else $error("lifted pitch below one octave");
`endif

endmodule

// ===== sim/scale_degree_to_cents_checker.sv =====
`timescale 1ns / 1ps

module scale_degree_to_cents_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        scale_select_we_i,
  input  logic [7:0]  scale_select_i,
  sdc_in_if           req_i,
  sdc_out_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pitch_pending_o,
  output int unsigned pitch_checked_o
);
  import sdc_pkg::*;

  localparam longint unsigned OCTAVE_CENTS_Q8 = 1200 * 256;
  localparam int unsigned     REPORT_LIMIT    = 10;

  logic [7:0]         tuning_q;
  logic [PITCH_W-1:0] pitch_due_q [$];
  int unsigned        mismatches = 0;
  int unsigned        checked    = 0;
  int unsigned        pending    = 0;

  assign mismatch_count_o = mismatches;
  assign pitch_pending_o  = pending;
  assign pitch_checked_o  = checked;

  // Interval sizes of the just tunings, in 1/256 cent, indexed by degree within the octave.
  function automatic longint unsigned interval_q8(input logic [7:0] tuning,
                                                  input longint unsigned idx);
    longint unsigned val;
    val = 0;
    if (tuning == SCALE_JI11) begin
      case (idx)
        1:  val = 38563;
        2:  val = 52201;
        3:  val = 68319;
        4:  val = 80804;
        5:  val = 98896;
        6:  val = 127500;
        7:  val = 141137;
        8:  val = 179700;
        9:  val = 195818;
        10: val = 208304;
        11: val = 226396;
        12: val = 248019;
        13: val = 268637;
        default: val = 0;
      endcase
    end else if (tuning == SCALE_PENTA) begin
      case (idx)
        1: val = 52198;
        2: val = 98893;
        3: val = 179712;
        4: val = 226406;
        default: val = 0;
      endcase
    end else if (tuning == SCALE_MAJOR) begin
      case (idx)
        1: val = 52198;
        2: val = 98893;
        3: val = 127488;
        4: val = 179712;
        5: val = 226406;
        6: val = 278605;
        default: val = 0;
      endcase
    end
    return val;
  endfunction

  // A degree of a just scale: the interval within the octave plus whole octaves.
  function automatic longint unsigned degree_q8(input logic [7:0] tuning,
                                                input longint unsigned notes,
                                                input longint unsigned degree);
    return interval_q8(tuning, degree % notes) + OCTAVE_CENTS_Q8 * (degree / notes);
  endfunction

  // One octave plus k steps of an n-division octave, rounded half up once.
  function automatic longint unsigned edo_q8(input longint unsigned k,
                                             input longint unsigned divisions);
    longint unsigned num;
    num = (divisions * 1200 + k * 1200) * 256;
    return (num + divisions / 2) / divisions;
  endfunction

  // Expected pitch of one lookup under the given tuning.
  function automatic logic [PITCH_W-1:0] predicted_pitch(input in_item_t lookup,
                                                         input logic [7:0] tuning);
    longint unsigned s;
    longint unsigned c;
    longint unsigned r;
    longint unsigned p;
    // Negative steps count as step zero; the grid position is clamped to the keyboard.
    s = lookup.step_index[STEP_W-1] ? 0 : lookup.step_index[STEP_W-2:0];
    if (lookup.grid_column[COL_W-1])
      c = 0;
    else if (lookup.grid_column[COL_W-2:0] > GRID_COLS - 1)
      c = GRID_COLS - 1;
    else
      c = lookup.grid_column[COL_W-2:0];
    if (lookup.grid_row[ROW_W-1])
      r = 0;
    else if (lookup.grid_row[ROW_W-2:0] > GRID_ROWS - 1)
      r = GRID_ROWS - 1;
    else
      r = lookup.grid_row[ROW_W-2:0];

    // The operation bit is set for a key on the grid and clear for a linear step.
    if (!lookup.operation) begin
      case (tuning)
        SCALE_EDO12: p = (1200 + 100 * s) * 256;
        SCALE_EDO19: p = edo_q8(s, 19);
        SCALE_EDO31: p = edo_q8(s, 31);
        SCALE_JI11:  p = degree_q8(tuning, GRID_COLS, s);
        SCALE_PENTA: p = degree_q8(tuning, 5, s);
        SCALE_MAJOR: p = degree_q8(tuning, 7, s);
        SCALE_WOLF:  p = (1200 + 62 * s) * 256;
        default:     p = 100 * s * 256;
      endcase
    end else begin
      case (tuning)
        SCALE_EDO12: p = (1200 + 100 * (c + 5 * r)) * 256;
        SCALE_EDO19: p = edo_q8(c + 8 * r, 19);
        SCALE_EDO31: p = edo_q8(c + 13 * r, 31);
        SCALE_JI11:  p = interval_q8(tuning, c) + OCTAVE_CENTS_Q8 * r;
        SCALE_PENTA: p = degree_q8(tuning, 5, c + 2 * r);
        SCALE_MAJOR: p = degree_q8(tuning, 7, c + 2 * r);
        SCALE_WOLF:  p = (1200 + 62 * c + 637 * r) * 256;
        // Unknown tunings ignore the row and have no octave lift.
        default:     p = 100 * c * 256;
      endcase
    end
    return p[PITCH_W-1:0];
  endfunction

  // Follow the tuning register, predict each accepted lookup and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin : track
    in_item_t           lookup;
    logic [PITCH_W-1:0] due;
    if (!rst_ni) begin
      tuning_q = SCALE_EDO12;
      pitch_due_q.delete();
    end else begin
      if (scale_select_we_i)
        tuning_q = scale_select_i;
      if (req_i.valid && req_i.ready) begin
        lookup.operation   = req_i.operation;
        lookup.step_index  = req_i.step_index;
        lookup.grid_column = req_i.grid_column;
        lookup.grid_row    = req_i.grid_row;
        pitch_due_q.push_back(predicted_pitch(lookup, tuning_q));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        checked++;
        if (pitch_due_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("Result %0d arrived with no lookup outstanding: pitch_cents_q8 %0d",
                     checked, rsp_i.pitch_cents_q8);
          mismatches++;
        end else begin
          due = pitch_due_q.pop_front();
          if (rsp_i.pitch_cents_q8 !== due) begin
            if (mismatches < REPORT_LIMIT)
              $display("Result %0d: pitch_cents_q8 expected %0d, got %0d (tuning %0d)",
                       checked, due, rsp_i.pitch_cents_q8, tuning_q);
            mismatches++;
          end
        end
      end
    end
    pending = pitch_due_q.size();
  end

endmodule

// ===== sim/scale_degree_to_cents_test.sv =====
`timescale 1ns / 1ps

module scale_degree_to_cents_test;
  import sdc_pkg::*;

  localparam int unsigned LOOKUPS_PER_TUNING = 100;
  localparam int unsigned TUNING_PHASES      = 15;
  localparam int unsigned CYCLE_LIMIT        = 400000;
  localparam int unsigned SETTLE_CYCLES      = 4;

  // Tuning ids outside the named set, which select the plain 100-cent fallback.
  localparam logic [7:0] FALLBACK_LOW = 8'd7;
  localparam logic [7:0] FALLBACK_TOP = 8'd255;

  typedef enum logic {LOOKUP_STEP = 1'b0, LOOKUP_GRID = 1'b1} lookup_e;
  typedef enum logic [1:0] {RX_FREE, RX_PATCHY, RX_CHOKED} rx_mode_e;

  logic        clk;
  logic        rst_n;
  logic        scale_select_we;
  logic [7:0]  scale_select;
  int unsigned mismatch_count;
  int unsigned pitch_pending;
  int unsigned pitch_checked;
  int unsigned step_lookups = 0;
  int unsigned grid_lookups = 0;
  int unsigned tunings_used = 1;
  int unsigned cycle_count  = 0;

  sdc_in_if  req_if ();
  sdc_out_if rsp_if ();

  scale_degree_to_cents i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .scale_select_we_i (scale_select_we),
    .scale_select_i    (scale_select),
    .req_i             (req_if),
    .rsp_o             (rsp_if)
  );

  scale_degree_to_cents_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .scale_select_we_i (scale_select_we),
    .scale_select_i    (scale_select),
    .req_i             (req_if),
    .rsp_i             (rsp_if),
    .mismatch_count_o  (mismatch_count),
    .pitch_pending_o   (pitch_pending),
    .pitch_checked_o   (pitch_checked)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pitch_pending);
    $display("Mismatches found");
    $finish;
  end

  // The receiver changes between free flow, random stalls and long stalls.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode          = RX_FREE;
    mode_left     = 0;
    hold_left     = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(30, 150);
      end
      mode_left--;
      case (mode)
        RX_FREE: begin
          rsp_if.ready <= 1'b1;
        end
        RX_PATCHY: begin
          rsp_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 12);
            rsp_if.ready <= 1'b1;
          end else begin
            hold_left--;
            rsp_if.ready <= 1'b0;
          end
        end
      endcase
    end
  end

  function automatic in_item_t make_step(input logic [STEP_W-1:0] step);
    in_item_t item;
    item.operation   = LOOKUP_STEP;
    item.step_index  = step;
    item.grid_column = COL_W'($urandom);
    item.grid_row    = ROW_W'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_grid(input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row);
    in_item_t item;
    item.operation   = LOOKUP_GRID;
    item.step_index  = STEP_W'($urandom);
    item.grid_column = col;
    item.grid_row    = row;
    return item;
  endfunction

  // Random lookup: mostly musical ranges, with extremes and out-of-range values mixed in.
  function automatic in_item_t random_lookup();
    in_item_t item;
    item.operation = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1: item.step_index = STEP_W'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0:       item.step_index = 11'h000;
          1:       item.step_index = 11'h3FF;
          2:       item.step_index = 11'h7FF;
          default: item.step_index = 11'h400;
        endcase
      end
      3, 4, 5, 6: item.step_index = STEP_W'($urandom_range(0, 60));
      default:    item.step_index = STEP_W'($urandom_range(0, 1023));
    endcase
    if ($urandom_range(0, 3) == 0)
      item.grid_column = COL_W'($urandom);
    else
      item.grid_column = COL_W'($urandom_range(0, GRID_COLS - 1));
    if ($urandom_range(0, 3) == 0)
      item.grid_row = ROW_W'($urandom);
    else
      item.grid_row = ROW_W'($urandom_range(0, GRID_ROWS - 1));
    return item;
  endfunction

  // Tuning for each random phase: every named tuning and one fallback id once, then random ids.
  function automatic logic [7:0] phase_tuning(input int unsigned phase);
    case (phase)
      0: return SCALE_EDO19;
      1: return SCALE_EDO31;
      2: return SCALE_JI11;
      3: return SCALE_PENTA;
      4: return SCALE_MAJOR;
      5: return SCALE_WOLF;
      6: return FALLBACK_LOW;
      7: return SCALE_EDO12;
      default: begin
        if ($urandom_range(0, 1) != 0)
          return 8'($urandom_range(SCALE_EDO12, FALLBACK_LOW));
        else
          return 8'($urandom_range(FALLBACK_LOW + 1, FALLBACK_TOP));
      end
    endcase
  endfunction

  // Present one item from a falling edge and hold it until accepted.
  task automatic send_lookup(input in_item_t item);
    req_if.valid       <= 1'b1;
    req_if.operation   <= item.operation;
    req_if.step_index  <= item.step_index;
    req_if.grid_column <= item.grid_column;
    req_if.grid_row    <= item.grid_row;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    if (item.operation == LOOKUP_GRID)
      grid_lookups++;
    else
      step_lookups++;
  endtask

  // Stop sending and wait until every expected pitch has come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pitch_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tuning(input logic [7:0] tuning);
    wait_idle();
    scale_select_we <= 1'b1;
    scale_select    <= tuning;
    @(negedge clk);
    scale_select_we <= 1'b0;
    tunings_used++;
  endtask

  // Random items in bursts, with gaps, back-to-back runs and occasional full drains.
  task automatic send_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left != 0) begin
      if ($urandom_range(0, 5) == 0)
        burst = $urandom_range(40, 80);
      else
        burst = $urandom_range(1, 16);
      if (burst > left)
        burst = left;
      repeat (burst) send_lookup(random_lookup());
      left -= burst;
      case ($urandom_range(0, 7))
        0: wait_idle();
        1, 2, 3: ;
        default: begin
          gap = $urandom_range(1, 8);
          req_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      endcase
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n              = 1'b0;
    scale_select_we    = 1'b0;
    scale_select       = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = 1'b0;
    req_if.step_index  = '0;
    req_if.grid_column = '0;
    req_if.grid_row    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Field extremes and clamping under the reset tuning.
    send_lookup(make_step(11'h000));
    send_lookup(make_step(11'h001));
    send_lookup(make_step(11'h3FF));
    send_lookup(make_step(11'h7FF));
    send_lookup(make_step(11'h400));
    send_lookup(make_step(11'h04D));
    send_lookup(make_grid(5'd0, 4'd0));
    send_lookup(make_grid(5'd13, 4'd3));
    send_lookup(make_grid(5'd14, 4'd4));
    send_lookup(make_grid(5'h0F, 4'h7));
    send_lookup(make_grid(5'h10, 4'h8));
    send_lookup(make_grid(5'h1F, 4'd2));
    send_lookup(make_grid(5'd6, 4'hF));
    send_lookup(make_grid(5'd9, 4'd1));

    // Unknown tuning: no octave lift, row ignored.
    write_tuning(FALLBACK_TOP);
    send_lookup(make_step(11'h3FF));
    send_lookup(make_step(11'h7F0));
    send_lookup(make_grid(5'd13, 4'd3));
    send_lookup(make_grid(5'h0F, 4'h7));
    send_lookup(make_grid(5'h1A, 4'd3));
    send_lookup(make_grid(5'd4, 4'd0));

    for (int phase = 0; phase < TUNING_PHASES; phase++) begin
      write_tuning(phase_tuning(phase));
      send_random(LOOKUPS_PER_TUNING);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("Covered %0d step and %0d grid lookups over %0d tuning settings,",
             step_lookups, grid_lookups, tunings_used);
    $display("including fallback ids and clamped positions; %0d pitches compared.",
             pitch_checked);
    if (mismatch_count == 0 && pitch_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
